### hdl/cpba_pkg.sv
package cpba_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned REQ_W     = 23;
  localparam int unsigned MAP_BITS  = 32;
  localparam int unsigned CHUNK_W   = 8;

  localparam logic       ACT_ALLOC   = 1'b0;
  localparam logic       ACT_FREE    = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;

  typedef struct packed {
    logic              action;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] run_first_addr;
    logic [ADDR_W-1:0] run_last_addr;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] first_page_addr;
    logic [ADDR_W-1:0] last_page_addr;
  } out_word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_UPD_RD,
    S_UPD_WR,
    S_DONE
  } state_e;

endpackage

### hdl/cpba_ram.sv
module cpba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/contiguous_page_bitmap_allocator.sv
// channel | direction | handshake                | word
// in      | input     | in_valid_i / in_stall_o   | in_word_t
// out     | output    | out_valid_o / out_stall_i | out_word_t
// cfg     | input     | cfg_valid_i / cfg_ready_o | region_base, 32 bits
//
// allocate: a setup step (S_CHECK), then the scan step reads each bitmap word chunk
//   by chunk (8 pages a cycle), then S_UPD_RD, S_UPD_WR per word marked, S_DONE to result
// free: S_CHECK, S_UPD_RD, S_UPD_WR per word cleared, S_DONE; bad requests: S_CHECK, S_DONE
// reset: a clearing pass writes zero to all (NUM_PAGES+31)/32 bitmap words,
//   one a cycle, while in_stall_o stays high; cfg writes are taken at any time
// one request at a time; a held result in the output register stalls only the
//   finish of the next request, not its acceptance
module contiguous_page_bitmap_allocator
  import cpba_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned NUM_PAGES  = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ADDR_W-1:0] cfg_data_i
);

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned MAP_WORDS  = (NUM_PAGES + 31) / 32;
  localparam int unsigned WORD_W     = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PIDX_W     = WORD_W + 5;
  localparam int unsigned PCNT_W     = $clog2(NUM_PAGES + 1);
  localparam logic [32:0] REGION_BYTES = 33'(NUM_PAGES) << PAGE_SHIFT;
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

  state_e              state_q, state_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [1:0]          chunk_q, chunk_d;
  logic [PCNT_W-1:0]   run_q, run_d;
  logic [PCNT_W-1:0]   need_q, need_d;
  logic [PIDX_W-1:0]   lo_q, lo_d;
  logic [PIDX_W-1:0]   hi_q, hi_d;
  logic                set_q, set_d;
  logic [1:0]          status_q, status_d;
  logic [ADDR_W-1:0]   base_q;
  logic                out_valid_q;
  out_word_t           out_word_q, out_word_d;
  in_word_t            req_q;

  logic                ram_we, ram_re;
  logic [WORD_W-1:0]   ram_waddr, ram_raddr;
  logic [MAP_BITS-1:0] ram_wdata, ram_rdata;

  logic                in_accept, out_free, out_load;

  // scan step
  logic [CHUNK_W-1:0]  chunk_bits;
  logic [PCNT_W-1:0]   run_v;
  logic                hit, stop, no_space;
  logic [2:0]          hit_j;
  logic [PIDX_W-1:0]   end_page;
  logic [31:0]         start_page;

  // request checks
  logic [23:0]         need_sum, need_full;
  logic                alloc_bad;
  logic [ADDR_W-1:0]   off_f, off_l, idx_f, idx_l;
  logic                free_bad;

  // range update
  logic [WORD_W-1:0]   lo_word, hi_word;
  logic [4:0]          lo_bit, hi_bit;
  logic [MAP_BITS-1:0] upd_mask;

  cpba_ram #(
    .WIDTH(MAP_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_DONE) && out_free;

  assign chunk_bits = ram_rdata[{chunk_q, 3'b000} +: CHUNK_W];

  always_comb begin
    logic [PIDX_W-1:0] pidx;
    run_v = run_q;
    hit   = 1'b0;
    stop  = 1'b0;
    hit_j = '0;
    pidx  = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      pidx = {word_q, chunk_q, 3'(j)};
      if (!hit && !stop) begin
        if (32'(pidx) >= 32'(NUM_PAGES)) begin
          stop = 1'b1;
        end else if (chunk_bits[j]) begin
          run_v = '0;
        end else begin
          run_v = run_v + 1'b1;
          if (run_v == need_q) begin
            hit   = 1'b1;
            hit_j = 3'(j);
          end
        end
      end
    end
  end

  assign no_space   = !hit && (stop || ((chunk_q == 2'd3) && (word_q == LAST_WORD)));
  assign end_page   = {word_q, chunk_q, hit_j};
  assign start_page = 32'(end_page) - 32'(need_q) + 32'd1;

  assign need_sum  = {1'b0, req_q.request_bytes} + 24'(PAGE_BYTES - 1);
  assign need_full = need_sum >> PAGE_SHIFT;
  assign alloc_bad = (req_q.request_bytes == '0) ||
                     (33'(req_q.request_bytes) > REGION_BYTES);

  assign off_f    = req_q.run_first_addr - base_q;
  assign off_l    = req_q.run_last_addr - base_q;
  assign idx_f    = off_f >> PAGE_SHIFT;
  assign idx_l    = off_l >> PAGE_SHIFT;
  assign free_bad = (off_f[PAGE_SHIFT-1:0] != '0) || (off_l[PAGE_SHIFT-1:0] != '0) ||
                    (idx_f >= 32'(NUM_PAGES)) || (idx_l >= 32'(NUM_PAGES)) ||
                    (idx_f > idx_l);

  assign lo_word  = lo_q[PIDX_W-1:5];
  assign hi_word  = hi_q[PIDX_W-1:5];
  assign lo_bit   = (word_q == lo_word) ? lo_q[4:0] : 5'd0;
  assign hi_bit   = (word_q == hi_word) ? hi_q[4:0] : 5'd31;
  assign upd_mask = ({MAP_BITS{1'b1}} << lo_bit) & ({MAP_BITS{1'b1}} >> (5'd31 - hi_bit));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (word_q == LAST_WORD) state_d = S_IDLE;
      S_IDLE:   if (in_accept) state_d = S_CHECK;
      S_CHECK: begin
        if (req_q.action == ACT_ALLOC) begin
          state_d = alloc_bad ? S_DONE : S_SCAN;
        end else begin
          state_d = free_bad ? S_DONE : S_UPD_RD;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_UPD_RD;
        end else if (no_space) begin
          state_d = S_DONE;
        end
      end
      S_UPD_RD: state_d = S_UPD_WR;
      S_UPD_WR: if (word_q == hi_word) state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    word_d     = word_q;
    chunk_d    = chunk_q;
    run_d      = run_q;
    need_d     = need_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    set_d      = set_q;
    status_d   = status_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = word_q;
    ram_raddr  = word_q;
    ram_wdata  = '0;
    out_word_d = out_word_q;
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (word_q != LAST_WORD) begin
          word_d = word_q + 1'b1;
        end
      end
      S_IDLE: begin
      end
      S_CHECK: begin
        if (req_q.action == ACT_ALLOC) begin
          if (alloc_bad) begin
            status_d = ST_BAD;
          end else begin
            need_d    = need_full[PCNT_W-1:0];
            word_d    = '0;
            chunk_d   = '0;
            run_d     = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
          end
        end else begin
          if (free_bad) begin
            status_d = ST_BAD;
          end else begin
            status_d = ST_DONE;
            lo_d     = idx_f[PIDX_W-1:0];
            hi_d     = idx_l[PIDX_W-1:0];
            set_d    = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          status_d = ST_DONE;
          lo_d     = start_page[PIDX_W-1:0];
          hi_d     = end_page;
          set_d    = 1'b1;
        end else if (no_space) begin
          status_d = ST_NO_SPACE;
        end else if (chunk_q == 2'd3) begin
          run_d     = run_v;
          chunk_d   = '0;
          word_d    = word_q + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = word_q + 1'b1;
        end else begin
          run_d   = run_v;
          chunk_d = chunk_q + 1'b1;
        end
      end
      S_UPD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = lo_word;
        word_d    = lo_word;
      end
      S_UPD_WR: begin
        ram_we    = 1'b1;
        ram_wdata = set_q ? (ram_rdata | upd_mask) : (ram_rdata & ~upd_mask);
        if (word_q != hi_word) begin
          ram_re    = 1'b1;
          ram_raddr = word_q + 1'b1;
          word_d    = word_q + 1'b1;
        end
      end
      S_DONE: begin
        out_word_d.status = status_q;
        if ((status_q == ST_DONE) && (req_q.action == ACT_ALLOC)) begin
          out_word_d.first_page_addr = base_q + (ADDR_W'(lo_q) << PAGE_SHIFT);
          out_word_d.last_page_addr  = base_q + (ADDR_W'(hi_q) << PAGE_SHIFT);
        end else begin
          out_word_d.first_page_addr = '0;
          out_word_d.last_page_addr  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      word_q      <= '0;
      chunk_q     <= '0;
      run_q       <= '0;
      need_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      set_q       <= 1'b0;
      status_q    <= ST_DONE;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      word_q   <= word_d;
      chunk_q  <= chunk_d;
      run_q    <= run_d;
      need_q   <= need_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      set_q    <= set_d;
      status_q <= status_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_word_i;
    end
    if (out_load) begin
      out_word_q <= out_word_d;
    end
  end

  a_no_same_word_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("bitmap read and write hit the same word");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (run_q < need_q))
    else $error("free run count passed the requested length");

  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_UPD_RD) || (state_q == S_UPD_WR)) |-> (lo_q <= hi_q))
    else $error("page range update with first page above last");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !out_valid_q) |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("finished request did not reach the output register");

endmodule
